// ----- hw/rtl/tvs_pkg.sv -----
// Shared types, codes and helpers for the typed variable store unit.
// No dependencies; every other file imports this package.
package tvs_pkg;

   localparam int GLOBAL_BYTES = 1024;
   localparam int LOCAL_BYTES  = 256;
   localparam int MAX_BYTES    = (GLOBAL_BYTES > LOCAL_BYTES) ? GLOBAL_BYTES : LOCAL_BYTES;
   localparam int GAW          = $clog2(GLOBAL_BYTES);
   localparam int LAW          = $clog2(LOCAL_BYTES);
   localparam int CLW          = $clog2(MAX_BYTES);
   // element addresses need 16 bits before the range check
   localparam int AW           = 17;
   localparam int BIT_IN_BYTE_MASK = 8 - 1;

   // request kinds
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_STORE = 2'd1;
   localparam logic [1:0] REQ_CALC  = 2'd2;
   localparam logic [1:0] REQ_CMP   = 2'd3;

   // variable types
   localparam logic [2:0] VT_NONE = 3'd0;
   localparam logic [2:0] VT_BIT  = 3'd1;
   localparam logic [2:0] VT_U8   = 3'd2;
   localparam logic [2:0] VT_S8   = 3'd3;
   localparam logic [2:0] VT_U16  = 3'd4;
   localparam logic [2:0] VT_S16  = 3'd5;
   localparam logic [2:0] VT_W32  = 3'd6;
   // unused type code, handled like none
   localparam logic [2:0] VT_RSVD = 3'd7;

   // calc ops
   localparam logic [3:0] OP_SET  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_ADD  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_MOD  = 4'd5;
   localparam logic [3:0] OP_AND  = 4'd6;
   localparam logic [3:0] OP_OR   = 4'd7;
   localparam logic [3:0] OP_XOR  = 4'd8;
   localparam logic [3:0] OP_SBIT = 4'd9;
   localparam logic [3:0] OP_CBIT = 4'd10;

   // compare ops
   localparam logic [3:0] CMP_ALWAYS = 4'd0;
   localparam logic [3:0] CMP_NEVER  = 4'd1;
   localparam logic [3:0] CMP_EQ    = 4'd2;
   localparam logic [3:0] CMP_NE    = 4'd3;
   localparam logic [3:0] CMP_GT    = 4'd4;
   localparam logic [3:0] CMP_GE    = 4'd5;
   localparam logic [3:0] CMP_LT    = 4'd6;
   localparam logic [3:0] CMP_LE    = 4'd7;
   localparam logic [3:0] CMP_ANDNZ = 4'd8;
   localparam logic [3:0] CMP_XORNZ = 4'd9;
   localparam logic [3:0] CMP_BSET  = 4'd10;

   // result status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNOP  = 2'd1;
   localparam logic [1:0] ST_DIV0  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_RD_ISSUE, S_RD_TAKE, S_EXEC, S_DIV, S_WRITE, S_DONE
   } state_type;

   // one byte access to the stores
   typedef struct packed {
      logic          region;
      logic          we;
      logic [AW-1:0] addr;
      logic [7:0]    wdata;
   } mem_req_type;

   function automatic logic [2:0] elem_bytes(input logic [2:0] vt);
      case (vt)
         VT_BIT, VT_U8, VT_S8: elem_bytes = 3'd1;
         VT_U16, VT_S16:       elem_bytes = 3'd2;
         VT_W32:               elem_bytes = 3'd4;
         default:              elem_bytes = 3'd0;
      endcase
   endfunction

   // raw little-endian bytes to a 32-bit value
   function automatic logic [31:0] extend(input logic [31:0] raw, input logic [2:0] vt,
                                          input logic [2:0] bitpos);
      case (vt)
         VT_BIT:  extend = {31'd0, raw[bitpos]};
         VT_U8:   extend = {24'd0, raw[7:0]};
         VT_S8:   extend = {{24{raw[7]}}, raw[7:0]};
         VT_U16:  extend = {16'd0, raw[15:0]};
         VT_S16:  extend = {{16{raw[15]}}, raw[15:0]};
         VT_W32:  extend = raw;
         default: extend = 32'd0;
      endcase
   endfunction

   function automatic logic [31:0] bit_mask(input logic [31:0] b);
      bit_mask = (b[31:5] == 27'd0) ? (32'd1 << b[4:0]) : 32'd0;
   endfunction

endpackage

// ----- hw/rtl/tvs_store.sv -----
// Global and local byte stores with a registered read.
// Depends on tvs_pkg; clears both stores after reset.
module tvs_store
   import tvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata,
   output logic        clear_done
);

   logic [7:0]     global_mem [GLOBAL_BYTES];
   logic [7:0]     local_mem  [LOCAL_BYTES];
   logic [7:0]     g_rd_ff, l_rd_ff;
   logic           region_ff;
   logic [CLW-1:0] clr_cnt_ff, clr_cnt_in;
   logic           clearing_ff, clearing_in;

   // advance the clearing pass
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLW'(MAX_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clearing_ff <= clearing_in;
      end
   end

   // global store port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         if ({1'b0, clr_cnt_ff} < (CLW + 1)'(GLOBAL_BYTES)) begin
            global_mem[clr_cnt_ff[GAW-1:0]] <= 8'd0;
         end
      end else if (mem_req.we && !mem_req.region) begin
         global_mem[mem_req.addr[GAW-1:0]] <= mem_req.wdata;
      end
      g_rd_ff <= global_mem[mem_req.addr[GAW-1:0]];
   end

   // local store port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         if ({1'b0, clr_cnt_ff} < (CLW + 1)'(LOCAL_BYTES)) begin
            local_mem[clr_cnt_ff[LAW-1:0]] <= 8'd0;
         end
      end else if (mem_req.we && mem_req.region) begin
         local_mem[mem_req.addr[LAW-1:0]] <= mem_req.wdata;
      end
      l_rd_ff   <= local_mem[mem_req.addr[LAW-1:0]];
      region_ff <= mem_req.region;
   end

   assign rdata      = region_ff ? l_rd_ff : g_rd_ff;
   assign clear_done = !clearing_ff;

endmodule

// ----- hw/rtl/tvs_divider.sv -----
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on tvs_pkg for style only; sign handling lives in the top level.
module tvs_divider
   import tvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[31]} - {1'b0, dsr_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial[32]) begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];

endmodule

// ----- hw/rtl/typed_variable_store_alu_top.sv -----
// Typed variable unit: load, store, calculate and compare over two byte stores.
// A request runs through address, a read issue and take per element byte, execute,
// the iterative divider for div or mod, one write per element byte, and done.
// One request at a time, busy while working; the next word is taken in the result cycle.
// Each word is shown one cycle on rsp_* with rsp_valid; the receiver cannot stall.
// After reset a clearing pass zeroes the stores while busy is high.
module typed_variable_store_alu_top
   import tvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic        req_region,
   input  logic [2:0]  req_var_type,
   input  logic [7:0]  req_bit_shift,
   input  logic [9:0]  req_var_offset,
   input  logic [12:0] req_element_index,
   input  logic signed [31:0] req_operand,
   input  logic [3:0]  req_op_code,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_value,
   output logic        rsp_flag,
   output logic [1:0]  rsp_status
);

   state_type state_ff, state_in;

   // latched request
   logic [1:0]  rt_ff;
   logic        rg_ff;
   logic [2:0]  vt_ff;
   logic [7:0]  sh_ff;
   logic [9:0]  off_ff;
   logic [12:0] idx_ff;
   logic [31:0] opnd_ff;
   logic [3:0]  op_ff;

   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]    bitpos_ff, bitpos_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [31:0]   raw_ff, raw_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   wval_ff, wval_in;
   logic          flag_ff, flag_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_value_ff;
   logic          rsp_flag_ff;
   logic [1:0]    rsp_status_ff;

   logic          accept;
   logic [2:0]    n_bytes;
   logic [AW-1:0] base, elem_addr, addr_end, region_size;
   logic [13:0]   bit_sum;
   logic [31:0]   cur;
   logic          need_write;
   logic          div_op;
   mem_req_type   mem_req;
   logic [7:0]    rdata;
   logic          clear_done;
   logic          div_start, div_done;
   logic [31:0]   div_a, div_b, div_q, div_r;
   logic [7:0]    wbyte;

   assign accept  = start && !busy;
   assign n_bytes = elem_bytes(vt_ff);
   assign cur     = extend(raw_ff, vt_ff, bitpos_ff);
   assign div_op  = (op_ff == OP_DIV) || (op_ff == OP_MOD);

   // form the element address and its end for the range check
   always_comb begin
      base    = rg_ff ? AW'({off_ff, 2'b00}) : AW'(off_ff);
      bit_sum = 14'(idx_ff) + 14'(sh_ff);
      case (vt_ff)
         VT_BIT:         elem_addr = base + AW'(bit_sum[13:3]);
         VT_U8, VT_S8:   elem_addr = base + AW'(idx_ff);
         VT_U16, VT_S16: elem_addr = base + AW'({idx_ff, 1'b0});
         VT_W32:         elem_addr = base + AW'({idx_ff, 2'b00});
         default:        elem_addr = base;
      endcase
      addr_end    = elem_addr + AW'(n_bytes);
      region_size = rg_ff ? AW'(LOCAL_BYTES) : AW'(GLOBAL_BYTES);
   end

   // signed magnitudes for the divider
   assign div_a = cur[31] ? (32'd0 - cur) : cur;
   assign div_b = opnd_ff[31] ? (32'd0 - opnd_ff) : opnd_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:    if (clear_done) state_in = S_IDLE;
         S_IDLE:     if (start) state_in = S_ADDR;
         S_ADDR: begin
            if (n_bytes != 3'd0 && addr_end > region_size) state_in = S_DONE;
            else if (n_bytes != 3'd0) state_in = S_RD_ISSUE;
            else state_in = S_EXEC;
         end
         S_RD_ISSUE: state_in = S_RD_TAKE;
         S_RD_TAKE:  state_in = (cnt_ff + 3'd1 == n_bytes) ? S_EXEC : S_RD_ISSUE;
         S_EXEC: begin
            if (rt_ff == REQ_CALC && div_op && opnd_ff != 32'd0) state_in = S_DIV;
            else if (need_write) state_in = S_WRITE;
            else state_in = S_DONE;
         end
         S_DIV:      if (div_done) state_in = (n_bytes != 3'd0) ? S_WRITE : S_DONE;
         S_WRITE:    if (cnt_ff + 3'd1 == n_bytes) state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // calc result and compare outcome for the execute step
   always_comb begin
      logic [31:0] v;
      logic        f;
      logic [1:0]  s;
      v = 32'd0;
      f = 1'b0;
      s = ST_OK;
      case (rt_ff)
         REQ_LOAD:  v = cur;
         REQ_STORE: v = 32'd0;
         REQ_CALC: begin
            case (op_ff)
               OP_SET:  v = opnd_ff;
               OP_SUB:  v = cur - opnd_ff;
               OP_ADD:  v = cur + opnd_ff;
               OP_MUL:  v = cur * opnd_ff;
               OP_DIV, OP_MOD: if (opnd_ff == 32'd0) s = ST_DIV0;
               OP_AND:  v = cur & opnd_ff;
               OP_OR:   v = cur | opnd_ff;
               OP_XOR:  v = cur ^ opnd_ff;
               OP_SBIT: v = cur | bit_mask(opnd_ff);
               OP_CBIT: v = cur & ~bit_mask(opnd_ff);
               default: s = ST_UNOP;
            endcase
         end
         default: begin
            v = cur;
            case (op_ff)
               CMP_ALWAYS: f = 1'b1;
               CMP_NEVER:  f = 1'b0;
               CMP_EQ:    f = (cur == opnd_ff);
               CMP_NE:    f = (cur != opnd_ff);
               CMP_GT:    f = ($signed(cur) > $signed(opnd_ff));
               CMP_GE:    f = ($signed(cur) >= $signed(opnd_ff));
               CMP_LT:    f = ($signed(cur) < $signed(opnd_ff));
               CMP_LE:    f = ($signed(cur) <= $signed(opnd_ff));
               CMP_ANDNZ: f = ((cur & opnd_ff) != 32'd0);
               CMP_XORNZ: f = ((cur ^ opnd_ff) != 32'd0);
               CMP_BSET:  f = ((cur & bit_mask(opnd_ff)) != 32'd0);
               default:   s = ST_UNOP;
            endcase
         end
      endcase
      if (s != ST_OK) begin
         v = 32'd0;
         f = 1'b0;
      end
      value_in   = v;
      flag_in    = f;
      status_in  = s;
      need_write = (n_bytes != 3'd0) && (s == ST_OK) &&
                   ((rt_ff == REQ_STORE) || (rt_ff == REQ_CALC));
      wval_in    = (rt_ff == REQ_STORE) ? opnd_ff : v;
   end

   // byte to write: merged bit for the bit type, else the next data byte
   always_comb begin
      wbyte = wval_ff[{cnt_ff[1:0], 3'b000} +: 8];
      if (vt_ff == VT_BIT) begin
         wbyte = raw_ff[7:0];
         wbyte[bitpos_ff] = (wval_ff != 32'd0);
      end
   end

   // outputs and datapath per state
   always_comb begin
      addr_in   = addr_ff;
      bitpos_in = bitpos_ff;
      cnt_in    = cnt_ff;
      raw_in    = raw_ff;
      div_start = 1'b0;
      mem_req.region = rg_ff;
      mem_req.we     = 1'b0;
      mem_req.addr   = addr_ff + AW'(cnt_ff);
      mem_req.wdata  = wbyte;
      case (state_ff)
         S_ADDR: begin
            addr_in   = elem_addr;
            bitpos_in = bit_sum[2:0] & 3'(BIT_IN_BYTE_MASK);
            cnt_in    = 3'd0;
            raw_in    = 32'd0;
         end
         S_RD_TAKE: begin
            raw_in[{cnt_ff[1:0], 3'b000} +: 8] = rdata;
            cnt_in = (cnt_ff + 3'd1 == n_bytes) ? 3'd0 : cnt_ff + 3'd1;
         end
         S_EXEC: begin
            div_start = (rt_ff == REQ_CALC) && div_op && (opnd_ff != 32'd0);
            cnt_in    = 3'd0;
         end
         S_WRITE: begin
            mem_req.we = 1'b1;
            cnt_in     = cnt_ff + 3'd1;
         end
         default: begin
         end
      endcase
   end

   // sequencer and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_DONE);
      end
      if (accept) begin
         rt_ff   <= req_type;
         rg_ff   <= req_region;
         vt_ff   <= req_var_type;
         sh_ff   <= req_bit_shift;
         off_ff  <= req_var_offset;
         idx_ff  <= req_element_index;
         opnd_ff <= req_operand;
         op_ff   <= req_op_code;
      end
      addr_ff   <= addr_in;
      bitpos_ff <= bitpos_in;
      cnt_ff    <= cnt_in;
      raw_ff    <= raw_in;
      if (state_ff == S_ADDR) begin
         value_ff  <= 32'd0;
         flag_ff   <= 1'b0;
         status_ff <= ST_RANGE;
      end else if (state_ff == S_EXEC) begin
         value_ff  <= value_in;
         flag_ff   <= flag_in;
         status_ff <= status_in;
         wval_ff   <= wval_in;
      end else if (state_ff == S_DIV && div_done) begin
         if (op_ff == OP_DIV) begin
            value_ff <= (cur[31] != opnd_ff[31]) ? (32'd0 - div_q) : div_q;
            wval_ff  <= (cur[31] != opnd_ff[31]) ? (32'd0 - div_q) : div_q;
         end else begin
            value_ff <= cur[31] ? (32'd0 - div_r) : div_r;
            wval_ff  <= cur[31] ? (32'd0 - div_r) : div_r;
         end
      end
      if (state_ff == S_DONE) begin
         rsp_value_ff  <= value_ff;
         rsp_flag_ff   <= flag_ff;
         rsp_status_ff <= status_ff;
      end
   end

   tvs_store u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_req    (mem_req),
      .rdata      (rdata),
      .clear_done (clear_done)
   );

   tvs_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_status = rsp_status_ff;

   // a result word arrives only once the unit is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // an accepted word keeps the unit busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not raise busy");

   // failing requests report zero value and flag
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == 32'sd0 && !rsp_flag))
      else $error("error result not cleared");

   // no store write on a request that failed
   a_no_err_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (status_ff == ST_OK)) else $error("write after error");

endmodule
